// ===== hw/rtl/click_detect_led_toggle_blink_defines.svh =====
// Assertion macros for the click detector.
// Used by click_detect_led_toggle_blink.sv; expects clk and arst_n in scope.
`ifndef CLICK_DETECT_LED_TOGGLE_BLINK_DEFINES_SVH
`define CLICK_DETECT_LED_TOGGLE_BLINK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("click detector check failed");

// next-cycle implication, checked out of reset
`define CLB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("click detector check failed");

`endif

// ===== hw/rtl/clb_pkg.sv =====
// Shared types, codes and reset values for the click detector.
// No dependencies; imported by click_detect_led_toggle_blink.
`timescale 1ns / 1ps

package clb_pkg;

	localparam int CntW   = 16;
	localparam int PhaseW = 3;
	localparam int RegIdxW = 2;

	localparam logic [CntW-1:0] DebounceReset    = 16'd50;
	localparam logic [CntW-1:0] DoubleClickReset = 16'd400;
	localparam logic [CntW-1:0] BlinkReset       = 16'd250;

	localparam logic [RegIdxW-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [RegIdxW-1:0] REG_DOUBLE_CLICK = 2'd1;
	localparam logic [RegIdxW-1:0] REG_BLINK        = 2'd2;

	localparam logic [PhaseW-1:0] PHASE_IDLE  = 3'd0;
	localparam logic [PhaseW-1:0] PHASE_DEB1  = 3'd1;
	localparam logic [PhaseW-1:0] PHASE_REL1  = 3'd2;
	localparam logic [PhaseW-1:0] PHASE_WAIT2 = 3'd3;
	localparam logic [PhaseW-1:0] PHASE_DEB2  = 3'd4;
	localparam logic [PhaseW-1:0] PHASE_REL2  = 3'd5;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DEB1  = 6'b000010,
		ST_REL1  = 6'b000100,
		ST_WAIT2 = 6'b001000,
		ST_DEB2  = 6'b010000,
		ST_REL2  = 6'b100000
	} click_state_t;

	function automatic logic [PhaseW-1:0] phase_code(input click_state_t st);
		logic [PhaseW-1:0] code;
		unique case (st)
			ST_DEB1:  code = PHASE_DEB1;
			ST_REL1:  code = PHASE_REL1;
			ST_WAIT2: code = PHASE_WAIT2;
			ST_DEB2:  code = PHASE_DEB2;
			ST_REL2:  code = PHASE_REL2;
			default:  code = PHASE_IDLE;
		endcase
		return code;
	endfunction

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (v == {CntW{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ===== hw/rtl/click_detect_led_toggle_blink.sv =====
// Button debounce, single/double click detector with LED toggle and blink mode.
// Depends on clb_pkg and click_detect_led_toggle_blink_defines.svh.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | button_level
//  out     | output    | out_valid/out_stall| led_on, single_click, double_click,
//          |           |                    | blink_active, button_phase
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One item per cycle unless stalled; results appear the cycle after acceptance.
// A single output register holds the result; in_stall is high only while that
// register is full and out_stall holds it.
// Reset clears all but the payload outputs; loads register defaults 50/400/250.
`timescale 1ns / 1ps
`include "click_detect_led_toggle_blink_defines.svh"

module click_detect_led_toggle_blink (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [clb_pkg::RegIdxW-1:0]   cfg_index,
	input  logic [clb_pkg::CntW-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          button_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          led_on,
	output logic                          single_click,
	output logic                          double_click,
	output logic                          blink_active,
	output logic [clb_pkg::PhaseW-1:0]    button_phase
);
	import clb_pkg::*;

	logic [CntW-1:0] debounce_q, double_click_q, blink_q;
	click_state_t    state_q, state_d;
	logic [CntW-1:0] click_elapsed_q, click_elapsed_d;
	logic [CntW-1:0] blink_elapsed_q, blink_elapsed_d;
	logic            pending_q, pending_d;
	logic            blink_mode_q, blink_mode_d;
	logic            led_q, led_d;
	logic            single_d, double_d;
	logic            pressed, accept;
	logic [CntW-1:0] click_inc, blink_inc;

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign pressed  = ~button_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DebounceReset;
			double_click_q <= DoubleClickReset;
			blink_q        <= BlinkReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data;
				REG_DOUBLE_CLICK: double_click_q <= cfg_data;
				REG_BLINK:        blink_q        <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		click_inc       = sat_inc(click_elapsed_q);
		blink_inc       = sat_inc(blink_elapsed_q);
		state_d         = state_q;
		click_elapsed_d = click_inc;
		blink_elapsed_d = blink_inc;
		single_d        = 1'b0;
		double_d        = 1'b0;
		blink_mode_d    = blink_mode_q;
		led_d           = led_q;

		unique case (state_q)
			ST_DEB1: begin
				if (click_inc >= debounce_q)
					state_d = pressed ? ST_REL1 : ST_IDLE;
			end
			ST_REL1: begin
				if (!pressed) begin
					state_d         = ST_WAIT2;
					click_elapsed_d = '0;
				end
			end
			ST_WAIT2: begin
				if (pressed) begin
					state_d         = ST_DEB2;
					click_elapsed_d = '0;
				end else if (click_inc >= double_click_q) begin
					single_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DEB2: begin
				if (click_inc >= debounce_q) begin
					if (pressed) begin
						state_d = ST_REL2;
					end else begin
						single_d = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_REL2: begin
				if (!pressed) begin
					double_d     = 1'b1;
					blink_mode_d = ~blink_mode_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				if (pressed) begin
					state_d         = ST_DEB1;
					click_elapsed_d = '0;
				end
			end
		endcase

		pending_d = pending_q | single_d;

		if (blink_mode_d) begin
			if (blink_inc >= blink_q) begin
				blink_elapsed_d = '0;
				led_d           = ~led_q;
			end
		end else if (pending_d) begin
			pending_d = 1'b0;
			led_d     = ~led_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			click_elapsed_q <= '0;
			blink_elapsed_q <= '0;
			pending_q       <= 1'b0;
			blink_mode_q    <= 1'b0;
			led_q           <= 1'b0;
		end else if (accept) begin
			state_q         <= state_d;
			click_elapsed_q <= click_elapsed_d;
			blink_elapsed_q <= blink_elapsed_d;
			pending_q       <= pending_d;
			blink_mode_q    <= blink_mode_d;
			led_q           <= led_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_on       <= led_d;
			single_click <= single_d;
			double_click <= double_d;
			blink_active <= blink_mode_d;
			button_phase <= phase_code(state_d);
		end
	end

	`CLB_ASSERT_SAME(a_click_exclusive, out_valid, !(single_click && double_click))
	`CLB_ASSERT_SAME(a_click_ends_idle, out_valid && (single_click || double_click),
		button_phase == PHASE_IDLE)
	`CLB_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
	`CLB_ASSERT_NEXT(a_double_flips_mode, accept && double_d, blink_mode_q != $past(blink_mode_q))

endmodule

// ===== tb/click_detect_led_toggle_blink_tb.sv =====
// Self-checking bench for the click detector: a tick-level predictor runs on every accepted
// item and the output checker compares each result field against it.
// Depends on clb_pkg and the click_detect_led_toggle_blink RTL.
`timescale 1ns / 1ps

module click_detect_led_toggle_blink_tb;
	import clb_pkg::*;

	localparam logic [RegIdxW-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic              led;
		logic              single;
		logic              dbl;
		logic              blink;
		logic [PhaseW-1:0] phase;
	} tick_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [RegIdxW-1:0]  cfg_index = '0;
	logic [CntW-1:0]     cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                button_level = 1'b1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                led_on;
	logic                single_click;
	logic                double_click;
	logic                blink_active;
	logic [PhaseW-1:0]   button_phase;

	// predictor state and register copies
	logic [PhaseW-1:0]   click_ph;
	logic [CntW-1:0]     click_cnt;
	logic [CntW-1:0]     blink_cnt;
	logic                toggle_pending;
	logic                blink_on;
	logic                led_lvl;
	logic [CntW-1:0]     debounce_lim;
	logic [CntW-1:0]     window_lim;
	logic [CntW-1:0]     blink_lim;

	tick_result_t        expected_q[$];
	int                  err_count = 0;
	int                  n_ticks = 0;
	int                  idle_pct = 0;
	int                  stall_pct = 0;
	int                  holds_asked = 0;
	int                  holds_served = 0;
	int                  hold_left = 0;
	int                  quiet_cycles = 0;

	click_detect_led_toggle_blink u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_on       (led_on),
		.single_click (single_click),
		.double_click (double_click),
		.blink_active (blink_active),
		.button_phase (button_phase)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_predictor();
		click_ph = PHASE_IDLE;
		click_cnt = '0;
		blink_cnt = '0;
		toggle_pending = 1'b0;
		blink_on = 1'b0;
		led_lvl = 1'b0;
		debounce_lim = DebounceReset;
		window_lim = DoubleClickReset;
		blink_lim = BlinkReset;
	endfunction

	function automatic tick_result_t predict_tick(input logic lvl);
		tick_result_t r;
		logic pressed;
		r = '0;
		pressed = !lvl;
		if (click_cnt != '1)
			click_cnt = click_cnt + 1'b1;
		if (blink_cnt != '1)
			blink_cnt = blink_cnt + 1'b1;
		case (click_ph)
			PHASE_DEB1: begin
				if (click_cnt >= debounce_lim)
					click_ph = pressed ? PHASE_REL1 : PHASE_IDLE;
			end
			PHASE_REL1: begin
				if (!pressed) begin
					click_ph = PHASE_WAIT2;
					click_cnt = '0;
				end
			end
			PHASE_WAIT2: begin
				if (pressed) begin
					click_ph = PHASE_DEB2;
					click_cnt = '0;
				end else if (click_cnt >= window_lim) begin
					r.single = 1'b1;
					click_ph = PHASE_IDLE;
				end
			end
			PHASE_DEB2: begin
				if (click_cnt >= debounce_lim) begin
					if (pressed) begin
						click_ph = PHASE_REL2;
					end else begin
						r.single = 1'b1;
						click_ph = PHASE_IDLE;
					end
				end
			end
			PHASE_REL2: begin
				if (!pressed) begin
					r.dbl = 1'b1;
					blink_on = !blink_on;
					click_ph = PHASE_IDLE;
				end
			end
			default: begin
				click_ph = PHASE_IDLE;
				if (pressed) begin
					click_ph = PHASE_DEB1;
					click_cnt = '0;
				end
			end
		endcase
		if (r.single)
			toggle_pending = 1'b1;
		if (blink_on) begin
			if (blink_cnt >= blink_lim) begin
				blink_cnt = '0;
				led_lvl = !led_lvl;
			end
		end else if (toggle_pending) begin
			toggle_pending = 1'b0;
			led_lvl = !led_lvl;
		end
		r.led = led_lvl;
		r.blink = blink_on;
		r.phase = click_ph;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [PhaseW-1:0] want,
		input logic [PhaseW-1:0] got);
		err_count++;
		$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{led_on, single_click, double_click, blink_active, button_phase};
			if (expected_q.size() == 0) begin
				err_count++;
				$display("%0t unexpected item: expected none actual %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got.led != want.led)
					report_field("led_on", PhaseW'(want.led), PhaseW'(got.led));
				if (got.single != want.single)
					report_field("single_click", PhaseW'(want.single), PhaseW'(got.single));
				if (got.dbl != want.dbl)
					report_field("double_click", PhaseW'(want.dbl), PhaseW'(got.dbl));
				if (got.blink != want.blink)
					report_field("blink_active", PhaseW'(want.blink), PhaseW'(got.blink));
				if (got.phase != want.phase)
					report_field("button_phase", want.phase, got.phase);
			end
		end
	end

	// receiver: random stall, or a long counted hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_tick(input logic lvl);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(predict_tick(lvl));
		n_ticks++;
	endtask

	task automatic send_run(input logic lvl, input int count);
		repeat (count)
			send_tick(lvl);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CntW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_DEBOUNCE:     debounce_lim = val;
			REG_DOUBLE_CLICK: window_lim = val;
			REG_BLINK:        blink_lim = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_random_config();
		write_reg(REG_DEBOUNCE, CntW'($urandom_range(0, 6)));
		write_reg(REG_DOUBLE_CLICK, CntW'($urandom_range(0, 12)));
		write_reg(REG_BLINK, CntW'($urandom_range(0, 10)));
	endtask

	// press, release, and often a second press, with lengths around the current limits
	task automatic click_burst();
		int press_a;
		int gap_a;
		press_a = $urandom_range(1, debounce_lim + 3);
		gap_a = $urandom_range(1, window_lim + 4);
		send_run(1'b0, press_a);
		if ($urandom_range(0, 9) == 0)
			send_tick(1'($urandom_range(0, 1)));
		send_run(1'b1, gap_a);
		if ($urandom_range(0, 1)) begin
			send_run(1'b0, $urandom_range(1, debounce_lim + 3));
			if ($urandom_range(0, 9) == 0)
				send_tick(1'($urandom_range(0, 1)));
			send_run(1'b1, $urandom_range(1, window_lim + 4));
		end
	endtask

	task automatic run_random(input int count, input int idle, input int stall);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = n_ticks + count;
		while (n_ticks < target) begin
			if ($urandom_range(0, 99) < 85)
				click_burst();
			else
				repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
		end
		settle();
	endtask

	task automatic test_reset_values();
		run_random(200, 0, 0);
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_DEBOUNCE, 16'd1);
		write_reg(REG_DOUBLE_CLICK, 16'd2);
		write_reg(REG_BLINK, 16'd0);
		send_run(1'b1, 3);
		// single click
		send_run(1'b0, 2);
		send_run(1'b1, 3);
		// double click turns blink on, LED toggles every tick
		send_run(1'b0, 2);
		send_tick(1'b1);
		send_run(1'b0, 2);
		send_tick(1'b1);
		// second press let go during its debounce: single, kept pending in blink mode
		send_run(1'b0, 2);
		send_tick(1'b1);
		send_tick(1'b0);
		send_run(1'b1, 2);
		// double click turns blink off and the pending toggle lands
		send_run(1'b0, 2);
		send_tick(1'b1);
		send_run(1'b0, 2);
		send_tick(1'b1);
		// press that does not survive debounce
		send_tick(1'b0);
		send_tick(1'b1);
		settle();
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_DOUBLE_CLICK, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		send_tick(1'b0);
		send_run(1'b1, 2);
		settle();
	endtask

	task automatic test_idling();
		set_random_config();
		run_random(270, 0, 0);
		set_random_config();
		run_random(270, 69, 0);
		set_random_config();
		run_random(270, 0, 69);
		set_random_config();
		run_random(270, 38, 38);
	endtask

	task automatic test_backpressure();
		set_random_config();
		idle_pct = 0;
		stall_pct = 0;
		holds_asked++;
		repeat (40) send_tick(1'($urandom_range(0, 1)));
		settle();
		run_random(60, 20, 20);
	endtask

	task automatic test_large_limits();
		idle_pct = 0;
		stall_pct = 0;
		send_run(1'b1, 30);
		settle();
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_DOUBLE_CLICK, 16'hFFFF);
		write_reg(REG_BLINK, 16'hFFFF);
		// press held far shorter than the debounce limit
		send_run(1'b0, 60);
		settle();
		write_reg(REG_DEBOUNCE, 16'd1);
		send_run(1'b1, 2);
		send_run(1'b0, 3);
		// long window keeps waiting for the second press
		send_run(1'b1, 10);
		send_run(1'b0, 3);
		send_run(1'b1, 2);
		// blink on with a long blink limit: no automatic toggle
		send_run(1'b0, 3);
		send_run(1'b1, 4);
		settle();
	endtask

	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_idling();
		test_backpressure();
		test_large_limits();
		settle();
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
